>>> rtl/avsd_pkg.sv
// Package for the attribute video scanline decoder: opcodes, register indexes,
// palette constants and the palette lookup function. Depends on nothing.
`default_nettype none

package avsd_pkg;

   // Item opcodes.
   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_BORDER = 2'd1;
   localparam logic [1:0] OP_BANK   = 2'd2;
   localparam logic [1:0] OP_TICK   = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_LAST_LINE  = 2'd0;
   localparam logic [1:0] CSR_TOP_BORDER = 2'd1;

   localparam int AVSD_BANK_BYTES = 8192;
   localparam int CELLS_PER_LINE  = 40;
   localparam int CELL_SIDE       = (CELLS_PER_LINE - 32) / 2;

   localparam logic [31:0] NORMAL_MASK  = 32'hFFD7D7D7;
   localparam logic [31:0] OPAQUE_BLACK = 32'hFF000000;
   localparam logic [31:0] BLUE_BITS    = 32'hFFFF0000;
   localparam logic [31:0] RED_BITS     = 32'hFF0000FF;
   localparam logic [31:0] GREEN_BITS   = 32'hFF00FF00;
   localparam logic [12:0] ATTR_BASE    = 13'h1800;

   localparam logic [8:0] LAST_LINE_RESET  = 9'd311;
   localparam logic [7:0] TOP_BORDER_RESET = 8'd63;

   // Enables between the sequencer and the video memory.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } vram_ctl_type;

   function automatic logic [31:0] palette_color(input logic [2:0] idx);
      logic [31:0] c;
      c = OPAQUE_BLACK;
      if (idx[0]) c = c | BLUE_BITS;
      if (idx[1]) c = c | RED_BITS;
      if (idx[2]) c = c | GREEN_BITS;
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/avsd_vram.sv
// Video memory of the scanline decoder: both banks in one array, one write and
// one registered read per cycle, with a zero-fill pass after reset. Uses avsd_pkg.
`default_nettype none

module avsd_vram
   import avsd_pkg::*;
#(
   parameter int BANK_BYTES = AVSD_BANK_BYTES
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire vram_ctl_type                        ctl,
   input  wire logic [$clog2(2*BANK_BYTES)-1:0]     wr_addr,
   input  wire logic [7:0]                          wr_data,
   input  wire logic [$clog2(2*BANK_BYTES)-1:0]     rd_addr,
   output logic      [7:0]                          rd_data,
   output logic                                     busy
);

   localparam int DEPTH = 2 * BANK_BYTES;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   logic [7:0]    mem [DEPTH];
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          clr_busy_ff, clr_busy_in;
   logic [7:0]    rd_data_ff;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // The fill pass owns the write port until every entry holds zero.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= 8'd0;
      end else if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

`default_nettype wire

>>> rtl/attribute_video_scanline_decoder_core.sv
// Top level of the attribute video scanline decoder: request decode, scanline
// sequencer, cell color logic and result register. Uses avsd_pkg and avsd_vram.
`default_nettype none

// How to use this block.
// Items enter on the req_ channel (valid/ready). A write, border or bank-select
// item produces no result and leaves the sequencer idle. A tick item runs
// the line sequencer, which emits results on the rsp_ channel (valid/ready):
// one invisible result for a line outside the window, or forty cells for a
// visible line, rsp_last marking the final one and rsp_vblank set on it when
// the frame wraps. A bitmap line has 8 border cells, which need no memory
// read, and 32 bitmap cells, each of which makes two reads on the single video
// memory read port (pixel byte, then attribute) before the color build.
// req_ready is high only while the sequencer is idle; the next item can be
// taken while the last result of a line still waits in the result register.
// When the receiver stalls, the sequencer holds its current cell until the
// result register frees up, so nothing is lost or repeated. After reset the
// video memory is zero-filled, one byte per cycle, covering all 2*BANK_BYTES
// bytes (16384 at the default size); req_ready stays low during that pass.
// The csr_ port is always ready and takes writes at any time.
module attribute_video_scanline_decoder_core
   import avsd_pkg::*;
#(
   parameter int BANK_BYTES = AVSD_BANK_BYTES
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic        req_bank,
   input  wire logic [12:0] req_addr,
   input  wire logic [7:0]  req_data,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_row,
   output logic [5:0]       rsp_cell_res,
   output logic [31:0]      rsp_fg_color,
   output logic [31:0]      rsp_bg_color,
   output logic [7:0]       rsp_pixel_mask,
   output logic             rsp_visible,
   output logic             rsp_vblank,
   output logic             rsp_last,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_data
);

   localparam int VRAM_AW = $clog2(2 * BANK_BYTES);
   localparam logic [VRAM_AW-1:0] BANK_BASE = VRAM_AW'(BANK_BYTES);
   localparam logic [5:0] SIDE_LO   = 6'(CELL_SIDE);
   localparam logic [5:0] SIDE_HI   = 6'(CELL_SIDE + 32);
   localparam logic [5:0] LAST_CELL = 6'(CELLS_PER_LINE - 1);

   // Sequencer states: idle, cell dispatch, pixel byte returned, attribute returned.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CELL = 4'b0010,
      ST_PIX  = 4'b0100,
      ST_ATTR = 4'b1000
   } seq_state_type;

   seq_state_type state_ff, state_in;
   logic [5:0]  cell_ff, cell_in;
   logic [7:0]  row_ff, row_in;
   logic        vis_ff, vis_in;
   logic        wrap_ff, wrap_in;
   logic        blink_ff, blink_in;
   logic [7:0]  pix_ff;

   logic [8:0]  line_ff, line_in;
   logic [7:0]  flash_ff, flash_in;
   logic [31:0] border_ff, border_in;
   logic        shown_ff, shown_in;
   logic [8:0]  last_line_ff, last_line_in;
   logic [7:0]  top_ff, top_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_row_ff, rsp_row_in;
   logic [5:0]  rsp_cell_ff, rsp_cell_in;
   logic [31:0] rsp_fg_ff, rsp_fg_in;
   logic [31:0] rsp_bg_ff, rsp_bg_in;
   logic [7:0]  rsp_mask_ff, rsp_mask_in;
   logic        rsp_vis_ff, rsp_vis_in;
   logic        rsp_vb_ff, rsp_vb_in;
   logic        rsp_last_ff, rsp_last_in;

   vram_ctl_type        vram_ctl;
   logic [VRAM_AW-1:0]  vram_wr_addr;
   logic [VRAM_AW-1:0]  vram_rd_addr;
   logic [7:0]          vram_rd_data;
   logic                vram_busy;

   logic        req_fire;
   logic        out_free;
   logic        load;
   logic        cell_is_last;
   logic        border_cell;
   logic [10:0] y_val;
   logic [7:0]  yy;
   logic [4:0]  x_pos;
   logic [12:0] pix_off;
   logic [12:0] attr_off;
   logic [12:0] rd_off;
   logic [31:0] ink;
   logic [31:0] paper;
   logic [31:0] cell_fg;
   logic [31:0] cell_bg;

   assign req_ready = (state_ff == ST_IDLE) && !vram_busy;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // Row of the scanline; the window is visible when the value lies in 0..255.
   assign y_val = {2'b00, line_ff} + 11'd32 - {3'b000, top_ff};

   // Cell geometry and the interleaved bitmap and attribute offsets.
   assign cell_is_last = (cell_ff == LAST_CELL);
   assign border_cell  = (row_ff[7:5] == 3'b000) || (row_ff[7:5] == 3'b111) ||
                         (cell_ff < SIDE_LO) || (cell_ff >= SIDE_HI);
   assign yy       = row_ff - 8'd32;
   assign x_pos    = 5'(cell_ff - SIDE_LO);
   assign pix_off  = {yy[7:6], yy[2:0], yy[5:3], x_pos};
   assign attr_off = ATTR_BASE | {3'b000, yy[7:3], x_pos};
   assign rd_off   = (state_ff == ST_CELL) ? pix_off : attr_off;

   assign vram_wr_addr = (req_bank ? BANK_BASE : '0) +
                         {{(VRAM_AW-13){1'b0}}, req_addr};
   assign vram_rd_addr = (shown_ff ? BANK_BASE : '0) +
                         {{(VRAM_AW-13){1'b0}}, rd_off};

   // Attribute byte: ink in bits 2..0, paper in 5..3, bright in 6, flash in 7.
   always_comb begin
      ink   = palette_color(vram_rd_data[2:0]);
      paper = palette_color(vram_rd_data[5:3]);
      if (vram_rd_data[7] && blink_ff) begin
         cell_fg = paper;
         cell_bg = ink;
      end else begin
         cell_fg = ink;
         cell_bg = paper;
      end
      if (!vram_rd_data[6]) begin
         cell_fg = cell_fg & NORMAL_MASK;
         cell_bg = cell_bg & NORMAL_MASK;
      end
   end

   // Sequencer and result loading.
   always_comb begin
      state_in     = state_ff;
      cell_in      = cell_ff;
      row_in       = row_ff;
      vis_in       = vis_ff;
      wrap_in      = wrap_ff;
      blink_in     = blink_ff;
      line_in      = line_ff;
      flash_in     = flash_ff;
      border_in    = border_ff;
      shown_in     = shown_ff;
      vram_ctl     = '0;
      load         = 1'b0;
      rsp_row_in   = rsp_row_ff;
      rsp_cell_in  = rsp_cell_ff;
      rsp_fg_in    = rsp_fg_ff;
      rsp_bg_in    = rsp_bg_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_vis_in   = rsp_vis_ff;
      rsp_vb_in    = rsp_vb_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  OP_WRITE: begin
                     vram_ctl.wr_en = 1'b1;
                  end
                  OP_BORDER: begin
                     border_in = palette_color(req_data[2:0]) & NORMAL_MASK;
                  end
                  OP_BANK: begin
                     shown_in = req_data[0];
                  end
                  OP_TICK: begin
                     // Line state is captured now; the counters move on at once.
                     row_in   = y_val[7:0];
                     vis_in   = (y_val[10:8] == 3'b000);
                     blink_in = flash_ff[4];
                     wrap_in  = (line_ff >= last_line_ff);
                     if (line_ff >= last_line_ff) begin
                        line_in  = 9'd0;
                        flash_in = flash_ff + 8'd1;
                     end else begin
                        line_in = line_ff + 9'd1;
                     end
                     cell_in  = 6'd0;
                     state_in = ST_CELL;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CELL: begin
            if (!vis_ff) begin
               if (out_free) begin
                  load        = 1'b1;
                  rsp_row_in  = 8'd0;
                  rsp_cell_in = 6'd0;
                  rsp_fg_in   = 32'd0;
                  rsp_bg_in   = 32'd0;
                  rsp_mask_in = 8'd0;
                  rsp_vis_in  = 1'b0;
                  rsp_vb_in   = wrap_ff;
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else if (border_cell) begin
               if (out_free) begin
                  load        = 1'b1;
                  rsp_row_in  = row_ff;
                  rsp_cell_in = cell_ff;
                  rsp_fg_in   = border_ff;
                  rsp_bg_in   = border_ff;
                  rsp_mask_in = 8'd0;
                  rsp_vis_in  = 1'b1;
                  rsp_vb_in   = wrap_ff && cell_is_last;
                  rsp_last_in = cell_is_last;
                  cell_in     = cell_ff + 6'd1;
                  state_in    = cell_is_last ? ST_IDLE : ST_CELL;
               end
            end else begin
               vram_ctl.rd_en = 1'b1;
               state_in       = ST_PIX;
            end
         end
         ST_PIX: begin
            // The pixel byte is on the read port; fetch the attribute next.
            vram_ctl.rd_en = 1'b1;
            state_in       = ST_ATTR;
         end
         ST_ATTR: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_row_in  = row_ff;
               rsp_cell_in = cell_ff;
               rsp_fg_in   = cell_fg;
               rsp_bg_in   = cell_bg;
               rsp_mask_in = pix_ff;
               rsp_vis_in  = 1'b1;
               rsp_vb_in   = wrap_ff && cell_is_last;
               rsp_last_in = cell_is_last;
               cell_in     = cell_ff + 6'd1;
               state_in    = cell_is_last ? ST_IDLE : ST_CELL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Configuration writes; indexes beyond the list are dropped.
   always_comb begin
      last_line_in = last_line_ff;
      top_in       = top_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LAST_LINE:  last_line_in = csr_data;
            CSR_TOP_BORDER: top_in       = csr_data[7:0];
            default: begin
               last_line_in = last_line_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         line_ff      <= 9'd0;
         flash_ff     <= 8'd0;
         border_ff    <= OPAQUE_BLACK;
         shown_ff     <= 1'b0;
         last_line_ff <= LAST_LINE_RESET;
         top_ff       <= TOP_BORDER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         line_ff      <= line_in;
         flash_ff     <= flash_in;
         border_ff    <= border_in;
         shown_ff     <= shown_in;
         last_line_ff <= last_line_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff     <= cell_in;
      row_ff      <= row_in;
      vis_ff      <= vis_in;
      wrap_ff     <= wrap_in;
      blink_ff    <= blink_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_fg_ff   <= rsp_fg_in;
      rsp_bg_ff   <= rsp_bg_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_vis_ff  <= rsp_vis_in;
      rsp_vb_ff   <= rsp_vb_in;
      rsp_last_ff <= rsp_last_in;
      if (state_ff == ST_PIX) begin
         pix_ff <= vram_rd_data;
      end
   end

   avsd_vram #(
      .BANK_BYTES (BANK_BYTES)
   ) u_vram (
      .clock   (clock),
      .reset   (reset),
      .ctl     (vram_ctl),
      .wr_addr (vram_wr_addr),
      .wr_data (req_data),
      .rd_addr (vram_rd_addr),
      .rd_data (vram_rd_data),
      .busy    (vram_busy)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row        = rsp_row_ff;
   assign rsp_cell_res   = rsp_cell_ff;
   assign rsp_fg_color   = rsp_fg_ff;
   assign rsp_bg_color   = rsp_bg_ff;
   assign rsp_pixel_mask = rsp_mask_ff;
   assign rsp_visible    = rsp_vis_ff;
   assign rsp_vblank     = rsp_vb_ff;
   assign rsp_last       = rsp_last_ff;

   // The sequencer never runs a line while the memory fill pass is active.
   a_no_seq_during_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !vram_busy)
      else $error("line sequencer active during memory fill");

   // Only the final item of a tick may be an invisible result.
   a_invisible_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_vis_ff) |-> (rsp_last_ff && rsp_mask_ff == 8'd0 &&
                                         rsp_fg_ff == 32'd0 && rsp_cell_ff == 6'd0))
      else $error("malformed invisible result");

   // Vblank is flagged only on the last item of a tick.
   a_vblank_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_vb_ff) |-> rsp_last_ff)
      else $error("vblank on a non-final result");

   // Side border cells carry no pixels and equal colors.
   a_side_border: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_vis_ff && (rsp_cell_ff < SIDE_LO || rsp_cell_ff >= SIDE_HI))
         |-> (rsp_mask_ff == 8'd0 && rsp_fg_ff == rsp_bg_ff))
      else $error("side border cell carries bitmap data");

endmodule

`default_nettype wire

>>> sim/attribute_video_scanline_decoder_core_tb.sv
// Self-checking testbench for attribute_video_scanline_decoder_core: a scanline predictor
// runs beside the block and every result item is compared field by field in order.
// Depends on avsd_pkg and the core RTL only.
`default_nettype none

module attribute_video_scanline_decoder_core_tb;
   import avsd_pkg::*;

   // Register indexes past the end of the register list; the block must ignore them.
   localparam logic [1:0] CSR_SPARE_A = 2'd2;
   localparam logic [1:0] CSR_SPARE_B = 2'd3;

   // Non-tick items produce no result, so a short settle covers them before a register
   // write. The closing wait covers the longest line plus margin.
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES    = 150;

   // One expected result item.
   typedef struct packed {
      logic [7:0]  row;
      logic [5:0]  col_pos;
      logic [31:0] fg;
      logic [31:0] bg;
      logic [7:0]  mask;
      logic        vis;
      logic        vblank;
      logic        last;
   } cell_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op    = OP_WRITE;
   logic        req_bank  = 1'b0;
   logic [12:0] req_addr  = '0;
   logic [7:0]  req_data  = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_row;
   logic [5:0]  rsp_cell_res;
   logic [31:0] rsp_fg_color;
   logic [31:0] rsp_bg_color;
   logic [7:0]  rsp_pixel_mask;
   logic        rsp_visible;
   logic        rsp_vblank;
   logic        rsp_last;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_LAST_LINE;
   logic [8:0]  csr_data  = '0;

   // Shadow copy of the block's state and registers, updated as each item is accepted.
   logic [7:0]  vram_shadow [2*AVSD_BANK_BYTES];
   logic [8:0]  line_ctr       = '0;
   logic [7:0]  flash_ctr      = '0;
   logic [31:0] border_argb    = OPAQUE_BLACK;
   logic        shown_bank     = 1'b0;
   logic [8:0]  last_line_cfg  = LAST_LINE_RESET;
   logic [7:0]  top_border_cfg = TOP_BORDER_RESET;
   int          frames_seen    = 0;

   cell_type    cells_due[$];
   int          mismatch_count = 0;
   bit          idling = 1'b1;
   int          rsp_hold = 0;

   attribute_video_scanline_decoder_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_bank       (req_bank),
      .req_addr       (req_addr),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_row        (rsp_row),
      .rsp_cell_res   (rsp_cell_res),
      .rsp_fg_color   (rsp_fg_color),
      .rsp_bg_color   (rsp_bg_color),
      .rsp_pixel_mask (rsp_pixel_mask),
      .rsp_visible    (rsp_visible),
      .rsp_vblank     (rsp_vblank),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Three-bit color index to ARGB: bit 0 adds blue, bit 1 red, bit 2 green.
   function automatic logic [31:0] argb_of(input logic [2:0] idx);
      return OPAQUE_BLACK | ({32{idx[0]}} & BLUE_BITS) | ({32{idx[1]}} & RED_BITS)
             | ({32{idx[2]}} & GREEN_BITS);
   endfunction

   // Applies one accepted item to the shadow state. A tick queues the cells that the
   // block must produce for the current line, then steps the line counter.
   function automatic void predict_item(input logic [1:0] op, input logic bank,
                                        input logic [12:0] addr, input logic [7:0] data);
      int          y;
      logic        frame_end;
      logic [7:0]  row;
      logic [7:0]  yy;
      logic [4:0]  x;
      logic [12:0] pix_off;
      logic [12:0] attr_off;
      logic [7:0]  attr;
      logic [31:0] ink;
      logic [31:0] paper;
      cell_type    c;
      case (op)
         OP_WRITE: begin
            vram_shadow[{bank, addr}] = data;
         end
         OP_BORDER: begin
            // The border never gets the bright attribute, so it is always dimmed.
            border_argb = argb_of(data[2:0]) & NORMAL_MASK;
         end
         OP_BANK: begin
            shown_bank = data[0];
         end
         OP_TICK: begin
            frame_end = (line_ctr >= last_line_cfg);
            y = int'(line_ctr) + 32 - int'(top_border_cfg);
            if (y >= 0 && y < 256) begin
               row = y[7:0];
               for (int col = 0; col < CELLS_PER_LINE; col++) begin
                  c = '0;
                  c.row = row;
                  c.col_pos = 6'(col);
                  c.vis = 1'b1;
                  if (row < 32 || row >= 224 || col < CELL_SIDE || col >= CELL_SIDE + 32) begin
                     c.fg = border_argb;
                     c.bg = border_argb;
                  end else begin
                     // Pixel bytes interleave thirds, character rows and pixel rows;
                     // attributes are one byte per eight-by-eight character.
                     yy = row - 8'd32;
                     x = 5'(col - CELL_SIDE);
                     pix_off = {yy[7:6], yy[2:0], yy[5:3], x};
                     attr_off = ATTR_BASE + {3'b000, yy[7:3], x};
                     attr = vram_shadow[{shown_bank, attr_off}];
                     ink = argb_of(attr[2:0]);
                     paper = argb_of(attr[5:3]);
                     if (attr[7] && flash_ctr[4]) begin
                        c.fg = paper;
                        c.bg = ink;
                     end else begin
                        c.fg = ink;
                        c.bg = paper;
                     end
                     if (!attr[6]) begin
                        c.fg = c.fg & NORMAL_MASK;
                        c.bg = c.bg & NORMAL_MASK;
                     end
                     c.mask = vram_shadow[{shown_bank, pix_off}];
                  end
                  c.last = (col == CELLS_PER_LINE - 1);
                  c.vblank = frame_end && c.last;
                  cells_due.push_back(c);
               end
            end else begin
               // A line outside the window gives one blank item.
               c = '0;
               c.last = 1'b1;
               c.vblank = frame_end;
               cells_due.push_back(c);
            end
            if (frame_end) begin
               line_ctr = '0;
               flash_ctr = flash_ctr + 8'd1;
               frames_seen++;
            end else begin
               line_ctr = line_ctr + 9'd1;
            end
         end
         default: begin
            frame_end = 1'b0;
         end
      endcase
   endfunction

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
   endtask

   // Result checker. Outputs are sampled at the rising edge, where a handshake completes.
   always @(posedge clock) begin
      cell_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (cells_due.size() == 0) begin
            report_mismatch("item with nothing expected", 32'(rsp_cell_res), '0);
         end else begin
            want = cells_due.pop_front();
            if (rsp_row !== want.row)
               report_mismatch("row", 32'(rsp_row), 32'(want.row));
            if (rsp_cell_res !== want.col_pos)
               report_mismatch("cell_res", 32'(rsp_cell_res), 32'(want.col_pos));
            if (rsp_fg_color !== want.fg)
               report_mismatch("fg_color", rsp_fg_color, want.fg);
            if (rsp_bg_color !== want.bg)
               report_mismatch("bg_color", rsp_bg_color, want.bg);
            if (rsp_pixel_mask !== want.mask)
               report_mismatch("pixel_mask", 32'(rsp_pixel_mask), 32'(want.mask));
            if (rsp_visible !== want.vis)
               report_mismatch("visible", 32'(rsp_visible), 32'(want.vis));
            if (rsp_vblank !== want.vblank)
               report_mismatch("vblank", 32'(rsp_vblank), 32'(want.vblank));
            if (rsp_last !== want.last)
               report_mismatch("last", 32'(rsp_last), 32'(want.last));
         end
      end
   end

   // Receiver back-pressure: random stalls while idling is enabled.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 11) == 0) begin
         rsp_hold <= $urandom_range(0, 17);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Sends one item. Called and returning at a falling edge. Valid stays high into the
   // next call unless a random gap is taken, so back-to-back items see no bubble.
   task automatic send_item(input logic [1:0] op, input logic bank, input logic [12:0] addr,
                            input logic [7:0] data);
      req_valid <= 1'b1;
      req_op    <= op;
      req_bank  <= bank;
      req_addr  <= addr;
      req_data  <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(op, bank, addr, data);
      @(negedge clock);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
   endtask

   // A tick whose unused fields carry random bits.
   task automatic send_tick();
      send_item(OP_TICK, 1'($urandom_range(0, 1)), 13'($urandom_range(0, 8191)),
                8'($urandom_range(0, 255)));
   endtask

   // An item with every field random, any operation.
   task automatic send_noise();
      send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)));
   endtask

   // Holds the sender off until every expected item has come back, then lets the block
   // settle so that it is idle before anything else happens.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (cells_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One register write. Valid drops after each write so back-to-back writes
   // never assign it twice in one step.
   task automatic write_csr(input logic [1:0] idx, input logic [8:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_LAST_LINE)
         last_line_cfg = value;
      else if (idx == CSR_TOP_BORDER)
         top_border_cfg = value[7:0];
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Runs one whole frame with the window at the top (bitmap from line 32 on).
   // Most items are ticks and writes aimed at the lines just ahead, so the bitmap
   // cells read fresh random bytes; the rest is noise, border and bank changes.
   task automatic raster_frame(input logic [8:0] last_line);
      int          start;
      int          pick;
      int          yy_pick;
      logic [7:0]  yy;
      logic [4:0]  x;
      logic [12:0] target;
      wait_drained();
      write_csr(CSR_TOP_BORDER, 9'd32);
      write_csr(CSR_LAST_LINE, last_line);
      start = frames_seen;
      while (frames_seen == start) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            send_tick();
         end else if (pick < 96) begin
            yy_pick = int'(line_ctr) - 32 + $urandom_range(0, 3);
            if (yy_pick < 0 || yy_pick > 191) yy_pick = $urandom_range(0, 191);
            yy = 8'(yy_pick);
            x = 5'($urandom_range(0, 31));
            if ($urandom_range(0, 1) == 0)
               target = {yy[7:6], yy[2:0], yy[5:3], x};
            else
               target = ATTR_BASE + {3'b000, yy[7:3], x};
            // Mostly the shown bank, sometimes the hidden one.
            send_item(OP_WRITE, ($urandom_range(0, 3) == 0) ? ~shown_bank : shown_bank,
                      target, 8'($urandom_range(0, 255)));
         end else if (pick < 97) begin
            send_noise();
         end else if (pick < 98) begin
            send_item(OP_BORDER, 1'($urandom_range(0, 1)), 13'($urandom_range(0, 8191)),
                      8'($urandom_range(0, 255)));
         end else if (pick < 99) begin
            send_item(OP_BANK, 1'($urandom_range(0, 1)), 13'($urandom_range(0, 8191)),
                      8'($urandom_range(0, 255)));
         end else begin
            wait_drained();
         end
      end
   endtask

   // Default registers: the first lines lie above the window and give blank items.
   task automatic test_reset_defaults();
      send_tick();
      send_tick();
      wait_drained();
   endtask

   // Spare indexes are ignored. A one-line-pair frame with the window off screen shows
   // vblank on blank items; with the window at the top, on border lines.
   task automatic test_register_writes();
      write_csr(CSR_SPARE_A, 9'($urandom_range(0, 511)));
      write_csr(CSR_SPARE_B, 9'($urandom_range(0, 511)));
      write_csr(CSR_LAST_LINE, 9'd1);
      // Bit 8 falls outside the eight-bit register, leaving 255.
      write_csr(CSR_TOP_BORDER, 9'h1FF);
      repeat (3) send_tick();
      wait_drained();
      write_csr(CSR_TOP_BORDER, 9'd32);
      repeat (2) send_tick();
      wait_drained();
   endtask

   // Border colors at both ends of the index, writes at both ends of both banks, and
   // bank selects that only look at bit 0.
   task automatic test_non_tick_ops();
      send_item(OP_BORDER, 1'b1, 13'h1FFF, 8'hFF);
      send_tick();
      send_item(OP_BORDER, 1'b0, 13'h0000, 8'hF8);
      send_tick();
      send_item(OP_WRITE, 1'b0, 13'h0000, 8'hFF);
      send_item(OP_WRITE, 1'b1, 13'h1FFF, 8'hFF);
      send_item(OP_WRITE, 1'b0, 13'h1FFF, 8'h00);
      send_item(OP_WRITE, 1'b1, 13'h0000, 8'hAA);
      send_item(OP_BANK, 1'b0, 13'h0AAA, 8'hFF);
      send_item(OP_BANK, 1'b1, 13'h1555, 8'hFE);
      send_item(OP_BORDER, 1'b0, 13'h0000, 8'h05);
      send_tick();
      wait_drained();
   endtask

   // A short frame whose bitmap lines are read with the flash phase off, so attribute
   // bit 7 must not swap the colors. Unwritten bytes still read as zero from reset.
   task automatic test_bitmap_window();
      raster_frame(9'($urandom_range(36, 44)));
   endtask

   // Two-line frames off screen wrap quickly until the flash phase turns on.
   task automatic test_flash_frames();
      wait_drained();
      write_csr(CSR_LAST_LINE, 9'd1);
      write_csr(CSR_TOP_BORDER, 9'd255);
      while (!flash_ctr[4]) begin
         if ($urandom_range(0, 3) != 0) send_tick();
         else send_noise();
      end
   endtask

   // A full frame down past the bitmap into the bottom border with flash swapping on.
   task automatic test_raster_walk();
      raster_frame(9'($urandom_range(224, 236)));
   endtask

   // Closing part with no stalls on either side: the widest frame and the lowest
   // window, then random register values, each under random items.
   task automatic test_quiet_tail();
      idling = 1'b0;
      wait_drained();
      write_csr(CSR_LAST_LINE, 9'd511);
      write_csr(CSR_TOP_BORDER, 9'd255);
      repeat (15) send_noise();
      wait_drained();
      write_csr(CSR_LAST_LINE, 9'($urandom_range(1, 511)));
      write_csr(CSR_TOP_BORDER, 9'($urandom_range(32, 255)));
      repeat (15) send_noise();
   endtask

   // Main sequence. The first item waits out the memory clearing pass after reset
   // through the handshake itself.
   initial begin
      foreach (vram_shadow[i]) vram_shadow[i] = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_register_writes();
      test_non_tick_ops();
      test_bitmap_window();
      test_flash_frames();
      test_raster_walk();
      test_quiet_tail();
      wait_drained();
      // Extra cycles catch any item the block sends that was never asked for.
      repeat (END_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("attribute_video_scanline_decoder_core_tb: PASS");
      end else begin
         $display("attribute_video_scanline_decoder_core_tb: FAIL");
      end
      $finish;
   end

   // Watchdog: the limit is several times the slowest legal run, including the
   // clearing pass and every cell stalled for the longest burst.
   initial begin
      #(24_000_000);
      $display("attribute_video_scanline_decoder_core_tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
rtl/avsd_pkg.sv
rtl/avsd_vram.sv
rtl/attribute_video_scanline_decoder_core.sv
sim/attribute_video_scanline_decoder_core_tb.sv
